/* rtl/tbp_pkg.sv */
// Shared types, sizes and counter helpers for the tournament branch predictor.
// Used by every module of the block; depends on nothing else.
package tbp_pkg;

  localparam int unsigned INDEX_BITS  = 11;
  localparam int unsigned TABLE_DEPTH = 1 << INDEX_BITS;
  localparam int unsigned ADDR_W      = 48;
  localparam int unsigned COUNT_W     = 32;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef logic [INDEX_BITS-1:0] idx_t;
  typedef logic [1:0]            ctr_t;
  typedef logic [COUNT_W-1:0]    count_t;
  typedef logic [QPTR_W-1:0]     qptr_t;
  typedef logic [QPTR_W:0]       qcnt_t;

  localparam ctr_t   CTR_MAX      = 2'd3;
  localparam ctr_t   CTR_MIN      = 2'd0;
  localparam ctr_t   DIR_RESET    = CTR_MAX;  // strongly taken
  localparam ctr_t   CHOOSE_RESET = CTR_MIN;  // strongly gshare
  localparam count_t COUNT_MAX    = '1;
  localparam qcnt_t  QUEUE_FULL   = qcnt_t'(QUEUE_DEPTH);

  // One classified branch on its way from the front to the back.
  typedef struct packed {
    idx_t gidx;
    idx_t bidx;
    logic taken;
  } branch_t;

  function automatic ctr_t sat_move(ctr_t c, logic up);
    ctr_t r;
    r = c;
    if (up) begin
      if (c != CTR_MAX) r = c + 2'd1;
    end else begin
      if (c != CTR_MIN) r = c - 2'd1;
    end
    return r;
  endfunction

  function automatic count_t sat_inc(count_t v);
    return (v == COUNT_MAX) ? COUNT_MAX : v + count_t'(1);
  endfunction

endpackage

/* rtl/tbp_front.sv */
// Front end: accepts resolved branches, forms the table indices and keeps
// the global history. Depends on tbp_pkg.
module tbp_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [tbp_pkg::ADDR_W-1:0]      branch_address_i,
  input  logic                            taken_i,
  input  logic                            busy_i,
  input  logic                            q_full_i,
  output logic                            q_push_o,
  output tbp_pkg::branch_t                q_data_o
);
  import tbp_pkg::*;

  idx_t hist_q, hist_d;
  idx_t addr_idx;

  assign addr_idx   = branch_address_i[INDEX_BITS-1:0];
  assign in_ready_o = !busy_i && !q_full_i;
  assign q_push_o   = in_valid_i && in_ready_o;

  always_comb begin
    q_data_o.gidx  = addr_idx ^ hist_q;
    q_data_o.bidx  = addr_idx;
    q_data_o.taken = taken_i;
  end

  // Shift the outcome into the history LSB.
  always_comb begin
    hist_d = hist_q;
    if (q_push_o) hist_d = {hist_q[INDEX_BITS-2:0], taken_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_q <= '0;
    end else begin
      hist_q <= hist_d;
    end
  end

endmodule

/* rtl/tbp_queue.sv */
// Short FIFO of classified branches between front and back end.
// Depends on tbp_pkg.
module tbp_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  tbp_pkg::branch_t push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output tbp_pkg::branch_t head_o
);
  import tbp_pkg::*;

  branch_t slots_q [QUEUE_DEPTH];
  qptr_t   wr_ptr_q, rd_ptr_q;
  qcnt_t   cnt_q;

  assign full_o  = (cnt_q == QUEUE_FULL);
  assign empty_o = (cnt_q == '0);
  assign head_o  = slots_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + qptr_t'(1);
      if (pop_i)  rd_ptr_q <= rd_ptr_q + qptr_t'(1);
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + qcnt_t'(1);
        2'b01:   cnt_q <= cnt_q - qcnt_t'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) slots_q[wr_ptr_q] <= push_data_i;
  end

endmodule

/* rtl/tbp_back.sv */
// Back end: counter tables with read-modify-write and forwarding, chooser,
// running counts and the output register. Depends on tbp_pkg.
module tbp_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        q_empty_i,
  input  tbp_pkg::branch_t            q_head_i,
  output logic                        q_pop_o,
  output logic                        busy_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        prediction_o,
  output logic                        used_bimodal_o,
  output logic                        gshare_guess_o,
  output logic                        bimodal_guess_o,
  output logic                        correct_o,
  output logic [tbp_pkg::COUNT_W-1:0] correct_count_o,
  output logic [tbp_pkg::COUNT_W-1:0] branch_count_o
);
  import tbp_pkg::*;

  // Tables: one write and one registered read each.
  ctr_t g_mem [TABLE_DEPTH];
  ctr_t b_mem [TABLE_DEPTH];
  ctr_t c_mem [TABLE_DEPTH];
  ctr_t g_rd_q, b_rd_q, c_rd_q;

  // Clearing pass after reset.
  logic busy_q;
  idx_t clr_idx_q;

  // Execute stage holds the item whose table data is in the read registers.
  logic    e_valid_q;
  branch_t e_q;
  logic    e_fire;

  // Last write per table, forwarded over the read that missed it.
  logic fwg_v_q, fwb_v_q;
  idx_t fwg_idx_q, fwb_idx_q;
  ctr_t fwg_d_q, fwb_d_q, fwc_d_q;

  ctr_t g_cnt, b_cnt, c_cnt, g_new, b_new, c_new;
  logic g_guess, b_guess, use_b, pred, g_ok, b_ok, ok;

  logic   we;
  idx_t   g_waddr, b_waddr;
  ctr_t   g_wdata, b_wdata, c_wdata;

  logic   out_valid_q;
  logic   pred_q, use_b_q, g_guess_q, b_guess_q, ok_q;
  count_t hit_q, seen_q, hit_new, seen_new;

  assign busy_o  = busy_q;
  assign e_fire  = e_valid_q && (!out_valid_q || out_ready_i);
  assign q_pop_o = !busy_q && !q_empty_i && (!e_valid_q || e_fire);

  always_comb begin
    g_cnt = (fwg_v_q && fwg_idx_q == e_q.gidx) ? fwg_d_q : g_rd_q;
    b_cnt = (fwb_v_q && fwb_idx_q == e_q.bidx) ? fwb_d_q : b_rd_q;
    c_cnt = (fwb_v_q && fwb_idx_q == e_q.bidx) ? fwc_d_q : c_rd_q;

    g_guess = g_cnt[1];
    b_guess = b_cnt[1];
    use_b   = c_cnt[1];
    pred    = use_b ? b_guess : g_guess;
    g_ok    = (g_guess == e_q.taken);
    b_ok    = (b_guess == e_q.taken);
    ok      = (pred == e_q.taken);

    g_new = sat_move(g_cnt, e_q.taken);
    b_new = sat_move(b_cnt, e_q.taken);
    c_new = c_cnt;
    if (g_ok && !b_ok)      c_new = sat_move(c_cnt, 1'b0);
    else if (b_ok && !g_ok) c_new = sat_move(c_cnt, 1'b1);

    hit_new  = ok ? sat_inc(hit_q) : hit_q;
    seen_new = sat_inc(seen_q);
  end

  always_comb begin
    we      = busy_q || e_fire;
    g_waddr = busy_q ? clr_idx_q : e_q.gidx;
    b_waddr = busy_q ? clr_idx_q : e_q.bidx;
    g_wdata = busy_q ? DIR_RESET : g_new;
    b_wdata = busy_q ? DIR_RESET : b_new;
    c_wdata = busy_q ? CHOOSE_RESET : c_new;
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      g_rd_q <= g_mem[q_head_i.gidx];
      b_rd_q <= b_mem[q_head_i.bidx];
      c_rd_q <= c_mem[q_head_i.bidx];
    end
    if (we) begin
      g_mem[g_waddr] <= g_wdata;
      b_mem[b_waddr] <= b_wdata;
      c_mem[b_waddr] <= c_wdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b1;
      clr_idx_q <= '0;
    end else if (busy_q) begin
      clr_idx_q <= clr_idx_q + idx_t'(1);
      if (clr_idx_q == '1) busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
      fwg_v_q     <= 1'b0;
      fwb_v_q     <= 1'b0;
      hit_q       <= '0;
      seen_q      <= '0;
    end else begin
      if (q_pop_o)     e_valid_q <= 1'b1;
      else if (e_fire) e_valid_q <= 1'b0;

      if (e_fire)           out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;

      if (busy_q) begin
        fwg_v_q <= 1'b0;
        fwb_v_q <= 1'b0;
      end else if (e_fire) begin
        fwg_v_q <= 1'b1;
        fwb_v_q <= 1'b1;
      end

      if (e_fire) begin
        hit_q  <= hit_new;
        seen_q <= seen_new;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) e_q <= q_head_i;
    if (e_fire) begin
      fwg_idx_q <= e_q.gidx;
      fwg_d_q   <= g_new;
      fwb_idx_q <= e_q.bidx;
      fwb_d_q   <= b_new;
      fwc_d_q   <= c_new;
      pred_q    <= pred;
      use_b_q   <= use_b;
      g_guess_q <= g_guess;
      b_guess_q <= b_guess;
      ok_q      <= ok;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign prediction_o    = pred_q;
  assign used_bimodal_o  = use_b_q;
  assign gshare_guess_o  = g_guess_q;
  assign bimodal_guess_o = b_guess_q;
  assign correct_o       = ok_q;
  assign correct_count_o = hit_q;
  assign branch_count_o  = seen_q;

endmodule

/* rtl/tournament_branch_predictor_unit.sv */
// Tournament branch predictor (gshare + bimodal with a 2-bit chooser).
// Top level; instantiates tbp_front, tbp_queue and tbp_back and uses tbp_pkg.
//
// Input channel (in_valid_i / in_ready_o) carries one resolved branch per
// item: its address (low INDEX_BITS bits used) and its actual outcome.
// Output channel (out_valid_o / out_ready_i) returns one result per item:
// chosen prediction, which component was used, both component guesses read
// before update, a correctness flag and saturating correct/branch counts.
//
// Throughput is one item per cycle while out_ready_i stays high. The front
// forms indices and shifts the history on acceptance; the back reads all
// three tables into registers together and writes back as the item leaves
// its execute stage, with a one-entry forward per table covering
// back-to-back hits on the same index.
//
// After reset a clearing pass writes all 2048 entries of each table, one
// entry per cycle, so in_ready_o stays low until it ends. When the receiver
// stalls, the result holds in the output register, the back stops, and the
// 4-entry queue absorbs items until it fills and in_ready_o drops.
module tournament_branch_predictor_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [tbp_pkg::ADDR_W-1:0]  branch_address_i,
  input  logic                        taken_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        prediction_o,
  output logic                        used_bimodal_o,
  output logic                        gshare_guess_o,
  output logic                        bimodal_guess_o,
  output logic                        correct_o,
  output logic [tbp_pkg::COUNT_W-1:0] correct_count_o,
  output logic [tbp_pkg::COUNT_W-1:0] branch_count_o
);
  import tbp_pkg::*;

  logic    busy, q_full, q_push, q_pop, q_empty;
  branch_t q_data, q_head;

  tbp_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .branch_address_i (branch_address_i),
    .taken_i          (taken_i),
    .busy_i           (busy),
    .q_full_i         (q_full),
    .q_push_o         (q_push),
    .q_data_o         (q_data)
  );

  tbp_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_data),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .empty_o     (q_empty),
    .head_o      (q_head)
  );

  tbp_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_empty_i       (q_empty),
    .q_head_i        (q_head),
    .q_pop_o         (q_pop),
    .busy_o          (busy),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .prediction_o    (prediction_o),
    .used_bimodal_o  (used_bimodal_o),
    .gshare_guess_o  (gshare_guess_o),
    .bimodal_guess_o (bimodal_guess_o),
    .correct_o       (correct_o),
    .correct_count_o (correct_count_o),
    .branch_count_o  (branch_count_o)
  );

endmodule

/* rtl/tbp_checker.sv */
// Port-level checks for the tournament branch predictor, bound to the top.
// Depends on tbp_pkg and tournament_branch_predictor_unit.
module tbp_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic                        prediction_o,
  input logic                        used_bimodal_o,
  input logic                        gshare_guess_o,
  input logic                        bimodal_guess_o,
  input logic                        correct_o,
  input logic [tbp_pkg::COUNT_W-1:0] correct_count_o,
  input logic [tbp_pkg::COUNT_W-1:0] branch_count_o
);
  import tbp_pkg::*;

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(branch_count_o)
      && $stable(correct_count_o) && $stable(prediction_o))
    else $error("stalled result changed");

  // The prediction reported is the chosen component's guess.
  a_pick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> prediction_o == (used_bimodal_o ? bimodal_guess_o : gshare_guess_o))
    else $error("prediction does not match chosen component");

  // Successive results advance the branch count by one until it saturates.
  a_seen_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i |=> !out_valid_o
      || branch_count_o == $past(branch_count_o) + count_t'(1)
      || $past(branch_count_o) == COUNT_MAX)
    else $error("branch count skipped or repeated");

  // Successive results advance the correct count by the correctness flag.
  a_hit_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i |=> !out_valid_o
      || correct_count_o == $past(correct_count_o) + count_t'(correct_o)
      || $past(correct_count_o) == COUNT_MAX)
    else $error("correct count out of step with correct flag");

  // Correct count never runs ahead of the branch count.
  a_hit_le: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> correct_count_o <= branch_count_o)
    else $error("correct count exceeds branch count");

endmodule

bind tournament_branch_predictor_unit tbp_checker u_tbp_checker (.*);
